// ----- hw/rtl/psk_pkg.sv -----
// ----------------------------------------------------------------------------
// psk_pkg: shared types and constants of the scan code decoder
// Scan code values, result kinds, the decoded operation record and the
// key translation table for scan code set 1.
// ----------------------------------------------------------------------------
package psk_pkg;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_BKSP = 2'd1,
        KIND_TX   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        BK_EXEC  = 2'd0,
        BK_PUSH2 = 2'd1,
        BK_POP   = 2'd2
    } t_back_state;

    typedef struct packed {
        logic       dec_emit;
        t_kind      dec_kind;
        logic [7:0] dec_value;
        logic       is_ack;
        logic       is_resend;
        logic       push_leds;
        logic [2:0] lock_val;
    } t_op;

    localparam logic [7:0] SC_CAPS       = 8'h3A;
    localparam logic [7:0] SC_NUM        = 8'h45;
    localparam logic [7:0] SC_SCROLL     = 8'h46;
    localparam logic [7:0] SC_LSHIFT_MK  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MK  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_BKSP       = 8'h0E;
    localparam logic [7:0] KB_ACK        = 8'hFA;
    localparam logic [7:0] KB_RESEND     = 8'hFE;
    localparam logic [7:0] LED_CMD       = 8'hED;
    localparam logic [7:0] ASCII_BS      = 8'h08;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;
    localparam logic [7:0] ASCII_UC_A    = 8'h41;
    localparam logic [7:0] ASCII_UC_Z    = 8'h5A;

    localparam int LOCK_CAPS   = 2;
    localparam int LOCK_NUM    = 1;
    localparam int LOCK_SCROLL = 0;

    function automatic logic [7:0] key_char(input logic [6:0] code, input logic shifted);
        logic [7:0] c;
        begin
            c = 8'h00;
            case (code)
                7'h02: c = shifted ? 8'h21 : 8'h31;
                7'h03: c = shifted ? 8'h22 : 8'h32;
                7'h04: c = shifted ? 8'h23 : 8'h33;
                7'h05: c = shifted ? 8'h24 : 8'h34;
                7'h06: c = shifted ? 8'h25 : 8'h35;
                7'h07: c = shifted ? 8'h26 : 8'h36;
                7'h08: c = shifted ? 8'h27 : 8'h37;
                7'h09: c = shifted ? 8'h28 : 8'h38;
                7'h0A: c = shifted ? 8'h29 : 8'h39;
                7'h0B: c = shifted ? 8'h7E : 8'h30;
                7'h0C: c = shifted ? 8'h3D : 8'h2D;
                7'h0D: c = shifted ? 8'h7E : 8'h5E;
                7'h10: c = 8'h51;
                7'h11: c = 8'h57;
                7'h12: c = 8'h45;
                7'h13: c = 8'h52;
                7'h14: c = 8'h54;
                7'h15: c = 8'h59;
                7'h16: c = 8'h55;
                7'h17: c = 8'h49;
                7'h18: c = 8'h4F;
                7'h19: c = 8'h50;
                7'h1A: c = shifted ? 8'h60 : 8'h40;
                7'h1B: c = shifted ? 8'h7B : 8'h5B;
                7'h1E: c = 8'h41;
                7'h1F: c = 8'h53;
                7'h20: c = 8'h44;
                7'h21: c = 8'h46;
                7'h22: c = 8'h47;
                7'h23: c = 8'h48;
                7'h24: c = 8'h4A;
                7'h25: c = 8'h4B;
                7'h26: c = 8'h4C;
                7'h27: c = shifted ? 8'h2B : 8'h3B;
                7'h28: c = shifted ? 8'h2A : 8'h3A;
                7'h2B: c = shifted ? 8'h7D : 8'h5D;
                7'h2C: c = 8'h5A;
                7'h2D: c = 8'h58;
                7'h2E: c = 8'h43;
                7'h2F: c = 8'h56;
                7'h30: c = 8'h42;
                7'h31: c = 8'h4E;
                7'h32: c = 8'h4D;
                7'h33: c = shifted ? 8'h3C : 8'h2C;
                7'h34: c = shifted ? 8'h3E : 8'h2E;
                7'h35: c = shifted ? 8'h3F : 8'h2F;
                7'h37: c = 8'h2A;
                7'h39: c = 8'h20;
                7'h47: c = 8'h37;
                7'h48: c = 8'h38;
                7'h49: c = 8'h39;
                7'h4A: c = 8'h2D;
                7'h4B: c = 8'h34;
                7'h4C: c = 8'h35;
                7'h4D: c = 8'h36;
                7'h4E: c = 8'h2B;
                7'h4F: c = 8'h31;
                7'h50: c = 8'h32;
                7'h51: c = 8'h33;
                7'h52: c = 8'h30;
                7'h53: c = 8'h2E;
                7'h73: c = shifted ? 8'h5F : 8'h5C;
                7'h7D: c = shifted ? 8'h7C : 8'h5C;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

// ----- hw/rtl/psk_if.sv -----
// ----------------------------------------------------------------------------
// psk_if: request channels of the scan code decoder
// Valid/ready channels for received keyboard bytes and for results.
// ----------------------------------------------------------------------------
interface psk_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface psk_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink (input valid, input kind, input value, input last, output ready);
endinterface

// ----- hw/rtl/psk_ram.sv -----
// ----------------------------------------------------------------------------
// psk_ram: generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module psk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/psk_front.sv -----
// ----------------------------------------------------------------------------
// psk_front: scan code classifier
// Tracks shift and lock state, translates make codes and builds one
// operation record per accepted request.
// ----------------------------------------------------------------------------
module psk_front import psk_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_wdata,
    psk_in_if.sink        i_in,
    input  logic          i_op_full,
    output logic          o_op_push,
    output t_op           o_op
);

    logic [2:0] r_init_lock;
    logic [1:0] r_shift;
    logic [2:0] r_lock;
    logic [1:0] n_shift;
    logic [2:0] n_lock;
    logic       shifted;
    logic       is_bksp;
    logic [7:0] ch;
    t_op        op;

    assign i_in.ready = !i_op_full;
    assign o_op_push  = i_in.valid && !i_op_full;
    assign o_op       = op;

    always_comb begin
        shifted = (r_shift != 2'b00);
        is_bksp = (i_in.rx_byte == SC_BKSP);
        ch      = i_in.rx_byte[7] ? 8'h00 : key_char(i_in.rx_byte[6:0], shifted);
        if ((ch >= ASCII_UC_A) && (ch <= ASCII_UC_Z) && (r_lock[LOCK_CAPS] == shifted)) begin
            ch = ch + CASE_OFFSET;
        end

        n_shift      = r_shift;
        n_lock       = r_lock;
        op.dec_emit  = 1'b0;
        op.dec_kind  = KIND_CHAR;
        op.dec_value = ch;
        op.is_ack    = 1'b0;
        op.is_resend = 1'b0;
        op.push_leds = 1'b0;

        if (i_in.cmd) begin
            n_lock       = r_init_lock;
            op.push_leds = 1'b1;
        end else begin
            op.dec_emit  = (ch != 8'h00) || is_bksp;
            op.dec_kind  = is_bksp ? KIND_BKSP : KIND_CHAR;
            op.dec_value = is_bksp ? ASCII_BS : ch;
            op.is_ack    = (i_in.rx_byte == KB_ACK);
            op.is_resend = (i_in.rx_byte == KB_RESEND);
            case (i_in.rx_byte)
                SC_LSHIFT_MK:  n_shift[0] = 1'b1;
                SC_RSHIFT_MK:  n_shift[1] = 1'b1;
                SC_LSHIFT_BRK: n_shift[0] = 1'b0;
                SC_RSHIFT_BRK: n_shift[1] = 1'b0;
                SC_CAPS: begin
                    n_lock[LOCK_CAPS] = !r_lock[LOCK_CAPS];
                    op.push_leds      = 1'b1;
                end
                SC_NUM: begin
                    n_lock[LOCK_NUM] = !r_lock[LOCK_NUM];
                    op.push_leds     = 1'b1;
                end
                SC_SCROLL: begin
                    n_lock[LOCK_SCROLL] = !r_lock[LOCK_SCROLL];
                    op.push_leds        = 1'b1;
                end
                default: begin
                end
            endcase
        end
        op.lock_val = n_lock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_lock <= 3'b000;
            r_shift     <= 2'b00;
            r_lock      <= 3'b000;
        end else begin
            if (i_cfg_we) begin
                r_init_lock <= i_cfg_wdata;
            end
            if (o_op_push) begin
                r_shift <= n_shift;
                r_lock  <= n_lock;
            end
        end
    end

endmodule

// ----- hw/rtl/psk_op_fifo.sv -----
// ----------------------------------------------------------------------------
// psk_op_fifo: two-entry operation queue
// Decouples the classifier from the command sender.
// ----------------------------------------------------------------------------
module psk_op_fifo import psk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_full,
    output logic o_valid,
    output t_op  o_data,
    input  logic i_pop
);

    t_op        r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/psk_back.sv -----
// ----------------------------------------------------------------------------
// psk_back: result emitter and keyboard command sender
// Emits decoded results, keeps the LED command queue in RAM and sends its
// bytes one at a time under the ACK and resend rules.
// ----------------------------------------------------------------------------
module psk_back import psk_pkg::*; #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_op_valid,
    input  t_op        i_op,
    output logic       o_op_pop,
    psk_out_if.source  o_out
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_back_state   r_state, n_state;
    logic          r_await, n_await;
    logic [7:0]    r_sent, n_sent;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    t_kind         r_out_kind, n_out_kind;
    logic [7:0]    r_out_value, n_out_value;
    logic          r_out_last, n_out_last;

    logic          out_free;
    logic          await_final;
    logic          resend;
    logic          has_res;
    logic          pop_will;
    logic          full;
    logic          go;
    logic          ram_we;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    psk_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.kind  = r_out_kind;
    assign o_out.value = r_out_value;
    assign o_out.last  = r_out_last;

    assign out_free    = !r_out_valid || o_out.ready;
    assign await_final = i_op.is_ack ? 1'b0 : r_await;
    assign resend      = i_op.is_resend && r_await;
    assign has_res     = i_op.dec_emit || resend;
    assign pop_will    = !await_final && ((r_count != '0) || i_op.push_leds);
    assign full        = (r_count == FULL_CNT);
    assign go          = i_op_valid && (!has_res || out_free);

    always_comb begin
        n_state     = r_state;
        n_await     = r_await;
        n_sent      = r_sent;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_wdata   = LED_CMD;
        ram_re      = 1'b0;
        o_op_pop    = 1'b0;

        case (r_state)
            BK_EXEC: begin
                if (go) begin
                    n_await = await_final;
                    if (has_res) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = resend ? KIND_TX : i_op.dec_kind;
                        n_out_value = resend ? r_sent : i_op.dec_value;
                        n_out_last  = !pop_will;
                    end
                    if (i_op.push_leds) begin
                        if (!full) begin
                            ram_we  = 1'b1;
                            n_tail  = (r_tail == LAST_PTR) ? '0 : r_tail + AW'(1);
                            n_count = r_count + CW'(1);
                        end
                        n_state = BK_PUSH2;
                    end else begin
                        o_op_pop = 1'b1;
                        if (pop_will) begin
                            ram_re  = 1'b1;
                            n_state = BK_POP;
                        end
                    end
                end
            end
            BK_PUSH2: begin
                ram_wdata = {5'b00000, i_op.lock_val};
                if (!full) begin
                    ram_we  = 1'b1;
                    n_tail  = (r_tail == LAST_PTR) ? '0 : r_tail + AW'(1);
                    n_count = r_count + CW'(1);
                end
                o_op_pop = 1'b1;
                if (!r_await) begin
                    ram_re  = 1'b1;
                    n_state = BK_POP;
                end else begin
                    n_state = BK_EXEC;
                end
            end
            BK_POP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_TX;
                    n_out_value = ram_rdata;
                    n_out_last  = 1'b1;
                    n_sent      = ram_rdata;
                    n_head      = (r_head == LAST_PTR) ? '0 : r_head + AW'(1);
                    n_count     = r_count - CW'(1);
                    n_await     = 1'b1;
                    n_state     = BK_EXEC;
                end
            end
            default: begin
                n_state = BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_EXEC;
            r_await     <= 1'b0;
            r_sent      <= 8'h00;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_await     <= n_await;
            r_sent      <= n_sent;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("Command queue count exceeds its depth.");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_POP) |-> (r_count != '0))
        else $error("Send started from an empty command queue.");

    a_push2_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_PUSH2) |-> (i_op_valid && i_op.push_leds))
        else $error("Second LED byte written without its operation.");

    a_send_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_POP && out_free) |=> (r_await && r_out_valid && r_out_last))
        else $error("Sent byte did not set the ACK wait.");

endmodule

// ----- hw/rtl/ps2_keyboard_scancode_decoder_top.sv -----
// ----------------------------------------------------------------------------
// ps2_keyboard_scancode_decoder_top: scan code set 1 keyboard decoder
// Translates keyboard bytes to characters and backspace events and sends
// queued LED commands to the keyboard.
//
//   Port         Dir   Contents
//   i_in         in    cmd, rx_byte (valid/ready)
//   o_out        out   kind, value, last (valid/ready)
//   i_cfg_we     in    write enable of initial_lock_bits
//   i_cfg_wdata  in    initial_lock_bits value
//
// A key byte, ACK or resend is handled in the sender's execute state.
// A lock key or an init request writes its two queue bytes in the execute and second-push states.
// Each byte sent from the command queue passes through the pop state for the registered RAM read.
// Input requests are taken while the two-entry operation queue has room,
// also while a result waits in the output register. Reset is synchronous
// and needs no clearing pass.
// ----------------------------------------------------------------------------
module ps2_keyboard_scancode_decoder_top import psk_pkg::*; #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    psk_in_if.sink     i_in,
    psk_out_if.source  o_out
);

    logic op_push;
    logic op_full;
    logic op_valid;
    logic op_pop;
    t_op  op_in;
    t_op  op_out;

    psk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_op_full   (op_full),
        .o_op_push   (op_push),
        .o_op        (op_in)
    );

    psk_op_fifo u_op_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .o_full  (op_full),
        .o_valid (op_valid),
        .o_data  (op_out),
        .i_pop   (op_pop)
    );

    psk_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op_out),
        .o_op_pop   (op_pop),
        .o_out      (o_out)
    );

endmodule
